// ===== hdl/output_pin_blink_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Output pin blink controller: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef OUTPUT_PIN_BLINK_CONTROLLER_DEFINES_SVH
`define OUTPUT_PIN_BLINK_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define OPBC_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define OPBC_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/opbc_pkg.sv =====
// ----------------------------------------------------------------------------
// opbc_pkg
// Types, codes and defaults shared by the blink controller files.
// ----------------------------------------------------------------------------
package opbc_pkg;

  localparam int DEF_TIME_BITS  = 16;
  localparam int DEF_COUNT_BITS = 8;

  localparam int MODE_W    = 2;
  localparam int DELAY_W   = 16;
  localparam int EVCODE_W  = 2;
  localparam int ELAPSED_W = 16;
  localparam int REPEATS_W = 8;
  localparam int MS_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_OFF   = 2'd1,
    MODE_ON    = 2'd2,
    MODE_BLINK = 2'd3
  } mode_t;

  localparam logic [EVCODE_W-1:0] EV_ON_AFTER  = 2'd0;
  localparam logic [EVCODE_W-1:0] EV_OFF_AFTER = 2'd1;
  localparam logic [EVCODE_W-1:0] EV_END_BLINK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REPEATS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_MS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOREVER = 2'd3;

  localparam logic [REPEATS_W-1:0] RST_REPEATS = 8'd1;
  localparam logic [MS_W-1:0]      RST_ON_MS   = 16'd1;
  localparam logic [MS_W-1:0]      RST_PERIOD  = 16'd2;

  typedef struct packed {
    logic [REPEATS_W-1:0] repeats;
    logic [MS_W-1:0]      on_ms;
    logic [MS_W-1:0]      period_ms;
    logic                 endless;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic [DELAY_W-1:0] delay_ms;
  } item_t;

  typedef struct packed {
    logic                 pin_level;
    logic                 event_valid;
    logic [EVCODE_W-1:0]  event_code;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } res_t;

endpackage

// ===== hdl/opbc_if.sv =====
// ----------------------------------------------------------------------------
// opbc channel interfaces
// Valid/ready channels for command requests and pin results.
// ----------------------------------------------------------------------------
interface opbc_in_if
  import opbc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [DELAY_W-1:0] delay_ms;

  modport source (output valid, output mode, output delay_ms, input ready);
  modport sink   (input valid, input mode, input delay_ms, output ready);
endinterface

interface opbc_out_if
  import opbc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 pin_level;
  logic                 event_valid;
  logic [EVCODE_W-1:0]  event_code;
  logic [ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, output pin_level, output event_valid,
                  output event_code, output elapsed_ms, input ready);
  modport sink   (input valid, input pin_level, input event_valid,
                  input event_code, input elapsed_ms, output ready);
endinterface

// ===== hdl/opbc_cfg.sv =====
// ----------------------------------------------------------------------------
// opbc_cfg
// Blink configuration registers behind a plain write port.
// ----------------------------------------------------------------------------
module opbc_cfg
  import opbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeats   <= RST_REPEATS;
      cfg_r.on_ms     <= RST_ON_MS;
      cfg_r.period_ms <= RST_PERIOD;
      cfg_r.endless   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPEATS: cfg_r.repeats   <= cfg_wdata[REPEATS_W-1:0];
        CFG_ON_MS:   cfg_r.on_ms     <= cfg_wdata[MS_W-1:0];
        CFG_PERIOD:  cfg_r.period_ms <= cfg_wdata[MS_W-1:0];
        CFG_FOREVER: cfg_r.endless   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/opbc_core.sv =====
// ----------------------------------------------------------------------------
// opbc_core
// Pin control state and the single-pass update for one request.
// ----------------------------------------------------------------------------
module opbc_core
  import opbc_pkg::*;
#(
  parameter int TIME_BITS  = DEF_TIME_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  localparam int CMP_W = (COUNT_BITS > REPEATS_W) ? COUNT_BITS : REPEATS_W;

  typedef enum logic [1:0] {
    DM_NONE  = 2'd0,
    DM_OFF   = 2'd1,
    DM_ON    = 2'd2,
    DM_BLINK = 2'd3
  } dm_t;

  typedef enum logic [1:0] {
    PH_FINISHED = 2'd0,
    PH_ON       = 2'd1,
    PH_WAIT     = 2'd2
  } ph_t;

  dm_t                  dm_r, dm_nxt;
  ph_t                  ph_r, ph_nxt;
  logic [TIME_BITS-1:0] cd_r, cd_nxt;
  logic                 run_r, run_nxt;
  logic [TIME_BITS-1:0] since_r, since_nxt;
  logic [COUNT_BITS-1:0] per_r, per_nxt;
  logic                 pin_r, pin_nxt;
  logic [TIME_BITS-1:0] held_on_r, held_on_nxt;
  logic [TIME_BITS-1:0] held_off_r, held_off_nxt;
  logic [REPEATS_W-1:0] held_rep_r, held_rep_nxt;
  logic                 held_fev_r, held_fev_nxt;

  logic                 expired;
  logic                 level;
  logic                 ev_v;
  logic [EVCODE_W-1:0]  ev_c;
  logic [TIME_BITS-1:0] ev_t;

  always_comb begin
    dm_nxt       = dm_r;
    ph_nxt       = ph_r;
    cd_nxt       = cd_r;
    run_nxt      = run_r;
    since_nxt    = since_r;
    per_nxt      = per_r;
    pin_nxt      = pin_r;
    held_on_nxt  = held_on_r;
    held_off_nxt = held_off_r;
    held_rep_nxt = held_rep_r;
    held_fev_nxt = held_fev_r;
    expired      = 1'b0;
    level        = (item.mode == MODE_ON);
    ev_v         = 1'b0;
    ev_c         = EV_ON_AFTER;
    ev_t         = '0;

    case (item.mode)
      MODE_TICK: begin
        if (dm_r != DM_NONE) begin
          since_nxt = since_r + TIME_BITS'(1);
        end
        // countdown decrements first, then is checked
        if (run_r) begin
          if (cd_r != '0) begin
            cd_nxt = cd_r - TIME_BITS'(1);
          end
          expired = (cd_nxt == '0);
        end
        level = (dm_r == DM_ON);
        case (dm_r)
          DM_OFF, DM_ON: begin
            if (expired) begin
              run_nxt   = 1'b0;
              ph_nxt    = level ? PH_ON : PH_FINISHED;
              pin_nxt   = level;
              since_nxt = '0;
            end
            if (ph_nxt != PH_WAIT) begin
              ev_v = 1'b1;
              ev_c = level ? EV_ON_AFTER : EV_OFF_AFTER;
              ev_t = since_nxt;
            end
          end
          DM_BLINK: begin
            if (ph_r == PH_ON) begin
              if (expired) begin
                ph_nxt    = PH_FINISHED;
                pin_nxt   = 1'b0;
                cd_nxt    = held_off_r;
                run_nxt   = 1'b1;
                since_nxt = '0;
              end
              ev_v = 1'b1;
              ev_c = (since_nxt != '0) ? EV_ON_AFTER : EV_OFF_AFTER;
              ev_t = since_nxt;
            end else if (ph_r == PH_FINISHED) begin
              ev_v = 1'b1;
              if (expired) begin
                per_nxt = held_fev_r ? '0 : per_r + COUNT_BITS'(1);
                if (CMP_W'(per_nxt) == CMP_W'(held_rep_r)) begin
                  dm_nxt    = DM_NONE;
                  ph_nxt    = PH_FINISHED;
                  pin_nxt   = 1'b0;
                  run_nxt   = 1'b0;
                  cd_nxt    = '0;
                  since_nxt = '0;
                end else begin
                  ph_nxt    = PH_ON;
                  pin_nxt   = 1'b1;
                  cd_nxt    = held_on_r;
                  run_nxt   = 1'b1;
                  since_nxt = '0;
                end
              end
              if (dm_nxt == DM_NONE) begin
                ev_c = EV_END_BLINK;
                ev_t = '0;
              end else begin
                ev_c = (since_nxt != '0) ? EV_OFF_AFTER : EV_ON_AFTER;
                ev_t = since_nxt;
              end
            end
          end
          default: ;
        endcase
      end
      MODE_OFF, MODE_ON: begin
        dm_nxt = level ? DM_ON : DM_OFF;
        if (item.delay_ms != '0) begin
          ph_nxt  = PH_WAIT;
          cd_nxt  = TIME_BITS'(item.delay_ms);
          run_nxt = 1'b1;
        end else begin
          ph_nxt    = level ? PH_ON : PH_FINISHED;
          pin_nxt   = level;
          run_nxt   = 1'b0;
          cd_nxt    = '0;
          since_nxt = '0;
          ev_v      = 1'b1;
          ev_c      = level ? EV_ON_AFTER : EV_OFF_AFTER;
        end
      end
      MODE_BLINK: begin
        // a start with no repeats, no on time or a short period is dropped
        if (cfg.repeats != '0 && cfg.on_ms != '0 && cfg.period_ms > cfg.on_ms) begin
          held_on_nxt  = TIME_BITS'(cfg.on_ms);
          held_off_nxt = TIME_BITS'(cfg.period_ms - cfg.on_ms);
          held_rep_nxt = cfg.repeats;
          held_fev_nxt = cfg.endless;
          pin_nxt      = 1'b1;
          dm_nxt       = DM_BLINK;
          ph_nxt       = PH_ON;
          per_nxt      = '0;
          cd_nxt       = TIME_BITS'(cfg.on_ms);
          run_nxt      = 1'b1;
          since_nxt    = '0;
          ev_v         = 1'b1;
          ev_c         = EV_ON_AFTER;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dm_r       <= DM_NONE;
      ph_r       <= PH_FINISHED;
      cd_r       <= '0;
      run_r      <= 1'b0;
      since_r    <= '0;
      per_r      <= '0;
      pin_r      <= 1'b0;
      held_on_r  <= '0;
      held_off_r <= '0;
      held_rep_r <= '0;
      held_fev_r <= 1'b0;
    end else if (step) begin
      dm_r       <= dm_nxt;
      ph_r       <= ph_nxt;
      cd_r       <= cd_nxt;
      run_r      <= run_nxt;
      since_r    <= since_nxt;
      per_r      <= per_nxt;
      pin_r      <= pin_nxt;
      held_on_r  <= held_on_nxt;
      held_off_r <= held_off_nxt;
      held_rep_r <= held_rep_nxt;
      held_fev_r <= held_fev_nxt;
    end
  end

  assign res.pin_level   = pin_nxt;
  assign res.event_valid = ev_v;
  assign res.event_code  = ev_v ? ev_c : EV_ON_AFTER;
  assign res.elapsed_ms  = ev_v ? ELAPSED_W'(ev_t) : '0;

endmodule

// ===== hdl/output_pin_blink_controller.sv =====
// ----------------------------------------------------------------------------
// output_pin_blink_controller
// Drives one output pin from tick, on/off and blink requests, one result each.
// ----------------------------------------------------------------------------
//  port    | dir | handshake        | payload
//  in_ch   | in  | valid/ready      | mode, delay_ms
//  out_ch  | out | valid/ready      | pin_level, event_valid, event_code, elapsed_ms
//  cfg_*   | in  | write enable     | cfg_index, cfg_wdata
//
// One request per cycle while out_ch.ready holds high; a result passes through
// the input register, then the result register, after its request is taken.
// The state update is a single pass of compares and counter steps per request.
// Reset (rst_n low, synchronous) clears state and loads register defaults.
// A stalled result holds; the input register then fills and in_ch.ready drops.
// ----------------------------------------------------------------------------
module output_pin_blink_controller
  import opbc_pkg::*;
#(
  parameter int TIME_BITS  = DEF_TIME_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  opbc_in_if.sink              in_ch,
  opbc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  cfg_t  cfg;
  item_t item_r;
  logic  in_vld_r;
  res_t  res;
  res_t  res_r;
  logic  out_vld_r;
  logic  advance;

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.mode     <= mode_t'(in_ch.mode);
      item_r.delay_ms <= in_ch.delay_ms;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  opbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  opbc_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_ch.valid       = out_vld_r;
  assign out_ch.pin_level   = res_r.pin_level;
  assign out_ch.event_valid = res_r.event_valid;
  assign out_ch.event_code  = res_r.event_code;
  assign out_ch.elapsed_ms  = res_r.elapsed_ms;

endmodule

// ===== hdl/opbc_checker.sv =====
// ----------------------------------------------------------------------------
// opbc_checker
// Port-level checks on the result channel of the blink controller.
// ----------------------------------------------------------------------------
`include "output_pin_blink_controller_defines.svh"

module opbc_checker
  import opbc_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 pin_level,
  input logic                 event_valid,
  input logic [EVCODE_W-1:0]  event_code,
  input logic [ELAPSED_W-1:0] elapsed_ms
);

  `OPBC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pin_level) && $stable(event_valid) && $stable(event_code) && $stable(elapsed_ms), "result changed while stalled")
  `OPBC_ASSERT_IMP(a_no_event_zero, clk, rst_n, out_valid && !event_valid, event_code == EV_ON_AFTER && elapsed_ms == '0, "event fields set without an event")
  `OPBC_ASSERT_IMP(a_end_blink_low, clk, rst_n, out_valid && event_valid && event_code == EV_END_BLINK, !pin_level && elapsed_ms == '0, "blink end with pin high or time set")
  `OPBC_ASSERT_IMP(a_code_known, clk, rst_n, out_valid && event_valid, event_code == EV_ON_AFTER || event_code == EV_OFF_AFTER || event_code == EV_END_BLINK, "unknown event code")

endmodule

bind output_pin_blink_controller opbc_checker u_opbc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pin_level   (out_ch.pin_level),
  .event_valid (out_ch.event_valid),
  .event_code  (out_ch.event_code),
  .elapsed_ms  (out_ch.elapsed_ms)
);

// ===== verif/tb_output_pin_blink_controller.sv =====
// ----------------------------------------------------------------------------
// tb_output_pin_blink_controller
// Self-checking bench for the blink controller. A predictor follows every
// request the block takes, and each pin result is compared with the oldest
// prediction. Both channels idle at random, and the sink holds off for a
// long stretch once. The run ends with a short stretch of back-to-back
// requests on a quiet channel.
// ----------------------------------------------------------------------------
module tb_output_pin_blink_controller;
  import opbc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef enum logic [1:0] {DRV_NONE, DRV_OFF, DRV_ON, DRV_BLINK} drive_t;
  typedef enum logic [1:0] {PH_IDLE, PH_HIGH, PH_WAIT} phase_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  opbc_in_if  in_ch();
  opbc_out_if out_ch();

  output_pin_blink_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register shadow, as last written
  logic [REPEATS_W-1:0] cfg_reps = RST_REPEATS;
  logic [MS_W-1:0]      cfg_on   = RST_ON_MS;
  logic [MS_W-1:0]      cfg_per  = RST_PERIOD;
  logic                 cfg_loop = 1'b0;

  // predictor state
  drive_t               drv;
  phase_t               ph;
  logic [MS_W-1:0]      cd_val;
  logic                 cd_run;
  logic [ELAPSED_W-1:0] since_chg;
  logic [REPEATS_W-1:0] periods;
  logic                 pin;
  logic [MS_W-1:0]      held_on;
  logic [MS_W-1:0]      held_off;
  logic [REPEATS_W-1:0] held_reps;
  logic                 held_loop;

  item_t pin_cmd_q[$];
  res_t  pin_result_q[$];

  bit in_fired;
  bit calm;
  bit long_hold_done;
  int items_taken;
  int results_seen;
  int bad_results;
  int src_gap;
  int sink_hold;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic res_t pin_step(input item_t req);
    res_t r;
    logic fire;
    logic lvl;
    logic hit;
    logic ended;
    logic [EVCODE_W-1:0] code;
    logic [ELAPSED_W-1:0] t;
    hit = 1'b0;
    ended = 1'b0;
    code = EV_ON_AFTER;
    t = '0;
    case (req.mode)
      MODE_TICK: begin
        fire = 1'b0;
        if (drv != DRV_NONE) since_chg = since_chg + 1'b1;
        if (cd_run) begin
          if (cd_val != 0) cd_val = cd_val - 1'b1;
          fire = (cd_val == 0);
        end
        if (drv == DRV_OFF || drv == DRV_ON) begin
          lvl = (drv == DRV_ON);
          if (fire) begin
            cd_run = 1'b0;
            ph = lvl ? PH_HIGH : PH_IDLE;
            pin = lvl;
            since_chg = '0;
          end
          if (ph != PH_WAIT) begin
            hit = 1'b1;
            code = lvl ? EV_ON_AFTER : EV_OFF_AFTER;
            t = since_chg;
          end
        end else if (drv == DRV_BLINK && ph == PH_HIGH) begin
          if (fire) begin
            ph = PH_IDLE;
            pin = 1'b0;
            cd_val = held_off;
            cd_run = 1'b1;
            since_chg = '0;
          end
          hit = 1'b1;
          code = (since_chg != 0) ? EV_ON_AFTER : EV_OFF_AFTER;
          t = since_chg;
        end else if (drv == DRV_BLINK && ph == PH_IDLE) begin
          if (fire) begin
            periods = held_loop ? '0 : periods + 1'b1;
            if (periods == held_reps) begin
              drv = DRV_NONE;
              pin = 1'b0;
              cd_run = 1'b0;
              cd_val = '0;
              since_chg = '0;
              ended = 1'b1;
            end else begin
              ph = PH_HIGH;
              pin = 1'b1;
              cd_val = held_on;
              cd_run = 1'b1;
              since_chg = '0;
            end
          end
          hit = 1'b1;
          if (ended) code = EV_END_BLINK;
          else begin
            code = (since_chg != 0) ? EV_OFF_AFTER : EV_ON_AFTER;
            t = since_chg;
          end
        end
      end
      MODE_OFF, MODE_ON: begin
        lvl = (req.mode == MODE_ON);
        drv = lvl ? DRV_ON : DRV_OFF;
        if (req.delay_ms != 0) begin
          ph = PH_WAIT;
          cd_val = req.delay_ms;
          cd_run = 1'b1;
        end else begin
          ph = lvl ? PH_HIGH : PH_IDLE;
          pin = lvl;
          cd_run = 1'b0;
          cd_val = '0;
          since_chg = '0;
          hit = 1'b1;
          code = lvl ? EV_ON_AFTER : EV_OFF_AFTER;
        end
      end
      default: begin
        // a blink with a zero count, zero on time or too short a period is dropped
        if (cfg_reps != 0 && cfg_on != 0 && cfg_per > cfg_on) begin
          held_on = cfg_on;
          held_off = cfg_per - cfg_on;
          held_reps = cfg_reps;
          held_loop = cfg_loop;
          pin = 1'b1;
          drv = DRV_BLINK;
          ph = PH_HIGH;
          periods = '0;
          cd_val = cfg_on;
          cd_run = 1'b1;
          since_chg = '0;
          hit = 1'b1;
          code = EV_ON_AFTER;
        end
      end
    endcase
    r.pin_level = pin;
    r.event_valid = hit;
    r.event_code = hit ? code : '0;
    r.elapsed_ms = hit ? t : '0;
    return r;
  endfunction

  // request acceptance, prediction and result checking
  always @(posedge clk) begin : track
    item_t cmd;
    res_t got;
    res_t want;
    if (!rst_n) begin
      drv = DRV_NONE;
      ph = PH_IDLE;
      cd_val = '0;
      cd_run = 1'b0;
      since_chg = '0;
      periods = '0;
      pin = 1'b0;
      held_on = '0;
      held_off = '0;
      held_reps = '0;
      held_loop = 1'b0;
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        cmd.mode = mode_t'(in_ch.mode);
        cmd.delay_ms = in_ch.delay_ms;
        pin_result_q.push_back(pin_step(cmd));
        items_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.pin_level = out_ch.pin_level;
        got.event_valid = out_ch.event_valid;
        got.event_code = out_ch.event_code;
        got.elapsed_ms = out_ch.elapsed_ms;
        if (pin_result_q.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("ERROR: result %0d arrived with nothing outstanding", results_seen);
        end else begin
          want = pin_result_q.pop_front();
          if (got.pin_level !== want.pin_level || got.event_valid !== want.event_valid ||
              got.event_code !== want.event_code || got.elapsed_ms !== want.elapsed_ms) begin
            bad_results++;
            if (bad_results <= 10)
              $display("ERROR: result %0d exp pin %0b ev %0b code %0d t %0d, got %0b %0b %0d %0d",
                       results_seen, want.pin_level, want.event_valid, want.event_code,
                       want.elapsed_ms, got.pin_level, got.event_valid, got.event_code,
                       got.elapsed_ms);
          end
        end
        results_seen++;
      end
    end
  end

  // request sender
  always @(negedge clk) begin
    item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else if (!in_ch.valid || in_fired) begin
      if (src_gap > 0) begin
        in_ch.valid <= 1'b0;
        src_gap--;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        in_ch.valid <= 1'b0;
        src_gap = $urandom_range(0, 18);
      end else if (pin_cmd_q.size() != 0) begin
        nxt = pin_cmd_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.mode <= nxt.mode;
        in_ch.delay_ms <= nxt.delay_ms;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink, with one long hold-off so the input side backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_hold = 0;
    end else if (!long_hold_done && items_taken >= 150 && pin_cmd_q.size() > 10) begin
      long_hold_done = 1'b1;
      sink_hold = 79;
      out_ch.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      sink_hold = $urandom_range(0, 18);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_req(input mode_t m, input int unsigned d);
    item_t it;
    it.mode = m;
    it.delay_ms = d[DELAY_W-1:0];
    pin_cmd_q.push_back(it);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_req(MODE_TICK, $urandom_range(0, 65535));
  endtask

  // wait until every request has been taken and every result has come back
  task automatic settle();
    do @(posedge clk);
    while (pin_cmd_q.size() != 0 || in_ch.valid || pin_result_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DAT_W-1:0];
    case (idx)
      CFG_REPEATS: cfg_reps = val[REPEATS_W-1:0];
      CFG_ON_MS:   cfg_on = val[MS_W-1:0];
      CFG_PERIOD:  cfg_per = val[MS_W-1:0];
      default:     cfg_loop = val[0];
    endcase
  endtask

  task automatic blink_setup(input int unsigned reps, input int unsigned on_t,
                             input int unsigned per_t, input bit loop_on);
    settle();
    reg_write(CFG_REPEATS, reps);
    reg_write(CFG_ON_MS, on_t);
    reg_write(CFG_PERIOD, per_t);
    reg_write(CFG_FOREVER, loop_on);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned reps;
    int unsigned on_t;
    int unsigned per_t;
    int unsigned d;
    int n;
    int ticks;
    bit loop_on;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.delay_ms = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: one period, one tick high, one tick low
    push_req(MODE_TICK, 0);
    push_req(MODE_TICK, 16'hFFFF);
    push_req(MODE_ON, 0);
    push_ticks(1);
    push_req(MODE_OFF, 3);
    push_ticks(4);
    push_req(MODE_ON, 16'hFFFF);
    push_ticks(1);
    push_req(MODE_OFF, 1);
    push_ticks(1);
    push_req(MODE_BLINK, 16'hAAAA);
    push_ticks(3);
    push_req(MODE_BLINK, 0);
    push_req(MODE_ON, 2);
    push_ticks(2);
    push_req(MODE_OFF, 16'h5555);
    push_ticks(1);
    push_req(MODE_OFF, 0);

    // starts that must be dropped
    blink_setup(0, 2, 5, 1'b0);
    push_req(MODE_BLINK, 0);
    push_ticks(1);
    blink_setup(255, 0, 65535, 1'b0);
    push_req(MODE_BLINK, 0);
    blink_setup(255, 65535, 65535, 1'b1);
    push_req(MODE_BLINK, 0);
    push_ticks(1);
    // widest legal settings, then an endless short blink stopped by a request
    blink_setup(255, 65534, 65535, 1'b1);
    push_req(MODE_BLINK, 0);
    push_ticks(2);
    blink_setup(1, 1, 3, 1'b1);
    push_req(MODE_BLINK, 0);
    push_ticks(10);
    push_req(MODE_OFF, 0);

    for (int p = 0; p < 7; p++) begin
      reps = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 4);
      on_t = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
      per_t = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : on_t + $urandom_range(1, 6);
      loop_on = ($urandom_range(0, 3) == 0);
      blink_setup(reps, on_t, per_t, loop_on);
      n = 0;
      while (n < 80) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // blink run long enough to finish where it can
            push_req(MODE_BLINK, $urandom_range(0, 65535));
            ticks = loop_on ? $urandom_range(4, 30) : per_t * reps + $urandom_range(0, 3);
            if (ticks > 40) ticks = 40;
            if (ticks < 1) ticks = 1;
            push_ticks(ticks);
            n += ticks + 1;
          end
          4, 5, 6: begin
            d = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            push_req($urandom_range(0, 1) ? MODE_ON : MODE_OFF, d);
            ticks = d + $urandom_range(0, 4);
            push_ticks(ticks);
            n += ticks + 1;
          end
          7: begin
            ticks = $urandom_range(1, 4);
            repeat (ticks) push_req(mode_t'($urandom_range(0, 3)), $urandom_range(0, 65535));
            n += ticks;
          end
          8: begin
            // on/off request cutting into a running blink
            push_req(MODE_BLINK, 0);
            push_ticks($urandom_range(0, 5));
            d = $urandom_range(0, 3);
            push_req($urandom_range(0, 1) ? MODE_ON : MODE_OFF, d);
            push_ticks(d + 2);
            n += 12;
          end
          default: begin
            ticks = $urandom_range(1, 6);
            push_ticks(ticks);
            n += ticks;
          end
        endcase
      end
    end

    // quiet channel: a finite blink runs out, then immediate and delayed changes
    calm = 1'b1;
    blink_setup(2, 3, 7, 1'b0);
    push_req(MODE_BLINK, 0);
    push_ticks(16);
    push_req(MODE_ON, 0);
    push_ticks(6);
    push_req(MODE_OFF, 5);
    push_ticks(8);

    do @(posedge clk);
    while (pin_cmd_q.size() != 0 || in_ch.valid || pin_result_q.size() != 0);
    repeat (8) @(posedge clk);
    bad_results += pin_result_q.size();
    if (bad_results == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
